// File: rtl/utu_pkg.sv
package utu_pkg;

    // Encoding class of one job, set by the front end
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,  // no code point bytes (a lone '?' prefix may still apply)
        K_QMARK = 3'd1,  // invalid value, one '?'
        K_B1    = 3'd2,
        K_B2    = 3'd3,
        K_B3    = 3'd4,
        K_B4    = 3'd5
    } t_kind;

    typedef struct packed {
        logic        pre_q;   // '?' for a dropped high surrogate comes first
        t_kind       kind;
        logic [20:0] cp;
    } t_job;

    localparam logic [7:0]  QMARK      = 8'h3F;
    localparam logic [31:0] SURR_LO    = 32'h0000_D800;
    localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
    localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
    localparam logic [31:0] LIM_B1     = 32'h0000_007F;
    localparam logic [31:0] LIM_B2     = 32'h0000_07FF;
    localparam logic [31:0] LIM_B3     = 32'h0000_FFFF;
    localparam logic [15:0] HIGH_LO    = 16'hD800;
    localparam logic [15:0] HIGH_HI    = 16'hDBFF;
    localparam logic [15:0] LOW_LO     = 16'hDC00;
    localparam logic [15:0] LOW_HI     = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h01_0000;

    function automatic t_kind f_classify(input logic [31:0] cp);
        t_kind k;
        if ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX) begin
            k = K_QMARK;
        end else if (cp <= LIM_B1) begin
            k = K_B1;
        end else if (cp <= LIM_B2) begin
            k = K_B2;
        end else if (cp <= LIM_B3) begin
            k = K_B3;
        end else begin
            k = K_B4;
        end
        return k;
    endfunction

endpackage

// File: rtl/utu_front.sv
module utu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_accept,
    input  logic [31:0]    i_code_unit,
    input  logic           i_end_of_buffer,
    output logic           o_job_push,
    output utu_pkg::t_job  o_job
);
    import utu_pkg::*;

    logic       r_format;
    logic       r_held_valid;
    logic [9:0] r_held_bits;
    logic       r_ended;

    logic       n_held_valid;
    logic [9:0] n_held_bits;
    logic       n_ended;
    t_job       job;
    logic [15:0] u16;

    assign u16 = i_code_unit[15:0];

    always_comb begin
        job          = '{pre_q: 1'b0, kind: K_NONE, cp: '0};
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        n_ended      = r_ended;
        if (!r_ended) begin
            if (r_format) begin
                if (i_code_unit == 32'd0) begin
                    n_ended = 1'b1;
                end else begin
                    job.kind = f_classify(i_code_unit);
                    job.cp   = i_code_unit[20:0];
                end
            end else begin
                n_held_valid = 1'b0;
                n_held_bits  = '0;
                if (r_held_valid && u16 >= LOW_LO && u16 <= LOW_HI) begin
                    job.kind = K_B4;
                    job.cp   = SUPP_BASE + {1'b0, r_held_bits, u16[9:0]};
                end else begin
                    job.pre_q = r_held_valid;
                    if (u16 == 16'd0) begin
                        n_ended = 1'b1;
                    end else if (u16 >= HIGH_LO && u16 <= HIGH_HI) begin
                        if (i_end_of_buffer) begin
                            job.kind = K_QMARK;
                        end else begin
                            n_held_valid = 1'b1;
                            n_held_bits  = u16[9:0];
                        end
                    end else begin
                        job.kind = f_classify({16'd0, u16});
                        job.cp   = {5'd0, u16};
                    end
                end
            end
        end
        if (i_end_of_buffer) begin
            n_held_valid = 1'b0;
            n_held_bits  = '0;
            n_ended      = 1'b0;
        end
    end

    assign o_job      = job;
    assign o_job_push = i_accept && (job.pre_q || job.kind != K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format     <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
            r_ended      <= 1'b0;
        end else if (i_cfg_we) begin
            r_format     <= i_cfg_wdata;
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else if (i_accept) begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
            r_ended      <= n_ended;
        end
    end

endmodule

// File: rtl/utu_jobq.sv
module utu_jobq #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  utu_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_rd,
    output utu_pkg::t_job  o_data,
    output logic           o_empty
);
    import utu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

    t_job          r_slot [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULLCNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/utu_back.sv
module utu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  utu_pkg::t_job  i_job,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_pop,
    output logic [7:0]     o_byte,
    output logic           o_last
);
    import utu_pkg::*;

    logic       r_busy;
    logic [7:0] r_bytes [4];
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0] enc [4];
    logic [2:0] enc_len;
    logic [7:0] n_bytes [4];
    logic [2:0] n_cnt;
    logic       emit;
    logic       last_emit;
    logic       load;

    // UTF-8 bytes of the incoming job
    always_comb begin
        enc[0]  = QMARK;
        enc[1]  = 8'h80 | {2'b00, i_job.cp[5:0]};
        enc[2]  = 8'h80 | {2'b00, i_job.cp[5:0]};
        enc[3]  = 8'h80 | {2'b00, i_job.cp[5:0]};
        enc_len = 3'd0;
        case (i_job.kind)
            K_QMARK: begin
                enc_len = 3'd1;
            end
            K_B1: begin
                enc[0]  = {1'b0, i_job.cp[6:0]};
                enc_len = 3'd1;
            end
            K_B2: begin
                enc[0]  = {3'b110, i_job.cp[10:6]};
                enc_len = 3'd2;
            end
            K_B3: begin
                enc[0]  = {4'b1110, i_job.cp[15:12]};
                enc[1]  = {2'b10, i_job.cp[11:6]};
                enc_len = 3'd3;
            end
            K_B4: begin
                enc[0]  = {5'b11110, i_job.cp[20:18]};
                enc[1]  = {2'b10, i_job.cp[17:12]};
                enc[2]  = {2'b10, i_job.cp[11:6]};
                enc_len = 3'd4;
            end
            default: begin
                enc_len = 3'd0;
            end
        endcase
        if (i_job.pre_q) begin
            n_bytes[0] = QMARK;
            n_bytes[1] = enc[0];
            n_bytes[2] = enc[1];
            n_bytes[3] = enc[2];
            n_cnt      = enc_len + 3'd1;
        end else begin
            n_bytes = enc;
            n_cnt   = enc_len;
        end
    end

    assign emit      = r_busy && (!r_out_valid || i_pop);
    assign last_emit = emit && ({1'b0, r_idx} + 3'd1 == r_cnt);
    assign load      = (!r_busy || last_emit) && !i_q_empty;
    assign o_q_pop   = load;

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_bytes;
            r_cnt   <= n_cnt;
        end
        if (emit) begin
            r_out_byte <= r_bytes[r_idx];
            r_out_last <= last_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (last_emit) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/utf16_utf32_to_utf8_transcoder_core.sv
// Channel  Handshake             Payload                         Dir
// input    push / full           i_code_unit, i_end_of_buffer    in
// result   pop / empty           o_out_byte, o_last_of_run       out
// config   i_cfg_we              i_cfg_wdata (input_format)      in
//
// The front end takes one code unit per cycle while the job queue has room.
// The back end emits one UTF-8 byte per cycle while the output register is free
// or popped; a job goes from the queue into the back-end byte buffer, then each
// byte into the output register.
// Synchronous active-low reset clears format, surrogate and string state.
// A stalled result holds in the output register; the queue absorbs the front.
module utf16_utf32_to_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_code_unit,
    input  logic        i_end_of_buffer,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);
    import utu_pkg::*;

    logic accept;      // input transaction this cycle
    logic job_push;
    t_job job_in;
    t_job job_out;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic out_valid;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Front: format register, held high surrogate, end-of-string tracking,
    // classifies each unit into a job (optional '?' prefix + code point class).
    utu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_code_unit     (i_code_unit),
        .i_end_of_buffer (i_end_of_buffer),
        .o_job_push      (job_push),
        .o_job           (job_in)
    );

    // Jobs that produce no bytes never enter the queue.
    utu_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    // Back: expands a job into bytes, one per cycle unless the output stalls, into the output register.
    utu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (job_out),
        .o_q_pop   (q_pop),
        .o_valid   (out_valid),
        .i_pop     (pop),
        .o_byte    (o_out_byte),
        .o_last    (o_last_of_run)
    );

    assign empty = !out_valid;

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utu_pkg::*;

    // Value of the one config register
    typedef enum logic {
        FMT_UTF16 = 1'b0,
        FMT_UTF32 = 1'b1
    } t_fmt;

    // One expected UTF-8 output byte
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_utf8_byte;

    // Settle time after the last expected byte has popped, before touching the
    // config register.
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        push            = 1'b0;
    logic        full;
    logic [31:0] i_code_unit     = '0;
    logic        i_end_of_buffer = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_wdata     = 1'b0;
    logic        empty;
    logic        pop             = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;

    utf16_utf32_to_utf8_transcoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_code_unit     (i_code_unit),
        .i_end_of_buffer (i_end_of_buffer),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run)
    );

    // ------------------------------------------------------------------
    // Transcoder shadow state and the bytes it still owes us
    // ------------------------------------------------------------------
    t_fmt        cur_fmt        = FMT_UTF16;
    logic        high_held      = 1'b0;
    logic [9:0]  high_held_bits = '0;
    logic        str_done       = 1'b0;

    t_utf8_byte  utf8_bytes_q[$];   // expected bytes, oldest first
    logic [7:0]  run_bytes[$];      // bytes of the unit being transcoded

    int errors         = 0;
    int units_sent     = 0;
    int live_units     = 0;         // units that reached a live string
    int bytes_checked  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200_000;
        $display("simulation failed");
        $finish;
    end

    // Append one byte to the current unit's output
    task automatic add_run_byte(input logic [7:0] v);
        run_bytes = {run_bytes, v};
    endtask

    // Append the UTF-8 form of one code point, or '?' if it has none
    task automatic encode_code_point(input logic [31:0] cp);
        if ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX) begin
            add_run_byte(QMARK);
        end else if (cp <= LIM_B1) begin
            add_run_byte(cp[7:0]);
        end else if (cp <= LIM_B2) begin
            add_run_byte({3'b110, cp[10:6]});
            add_run_byte({2'b10, cp[5:0]});
        end else if (cp <= LIM_B3) begin
            add_run_byte({4'b1110, cp[15:12]});
            add_run_byte({2'b10, cp[11:6]});
            add_run_byte({2'b10, cp[5:0]});
        end else begin
            add_run_byte({5'b11110, cp[20:18]});
            add_run_byte({2'b10, cp[17:12]});
            add_run_byte({2'b10, cp[11:6]});
            add_run_byte({2'b10, cp[5:0]});
        end
    endtask

    // Advance the shadow state by one accepted unit and queue its bytes
    task automatic transcode_unit(input logic [31:0] cu, input logic eob);
        logic [15:0] u16;
        logic        paired;
        t_utf8_byte  b;
        run_bytes.delete();
        u16    = cu[15:0];
        paired = 1'b0;
        if (!str_done) begin
            if (cur_fmt == FMT_UTF32) begin
                if (cu == 32'h0) begin
                    str_done = 1'b1;
                end else begin
                    encode_code_point(cu);
                end
            end else begin
                // a held high surrogate is settled first by whatever follows
                if (high_held) begin
                    high_held = 1'b0;
                    if (u16 >= LOW_LO && u16 <= LOW_HI) begin
                        encode_code_point(32'(SUPP_BASE) + {high_held_bits, u16[9:0]});
                        paired = 1'b1;
                    end else begin
                        add_run_byte(QMARK);
                    end
                    high_held_bits = '0;
                end
                if (!paired) begin
                    if (u16 == 16'h0) begin
                        str_done = 1'b1;
                    end else if (u16 >= HIGH_LO && u16 <= HIGH_HI) begin
                        // nothing can follow a high surrogate at buffer end
                        if (eob) begin
                            add_run_byte(QMARK);
                        end else begin
                            high_held      = 1'b1;
                            high_held_bits = u16[9:0];
                        end
                    end else begin
                        encode_code_point({16'h0, u16});
                    end
                end
            end
        end
        foreach (run_bytes[i]) begin
            b.data = run_bytes[i];
            b.last = (i == run_bytes.size() - 1);
            utf8_bytes_q = {utf8_bytes_q, b};
        end
        if (eob) begin
            high_held      = 1'b0;
            high_held_bits = '0;
            str_done       = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: one transaction per call; push stays high afterwards so
    // back-to-back calls stream. Anything that waits must drop push first.
    // ------------------------------------------------------------------
    task automatic send_unit(input logic [31:0] cu, input logic eob);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_code_unit     <= cu;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (full);
        if (!str_done) live_units++;
        units_sent++;
        transcode_unit(cu, eob);
    endtask

    // Stop sending and wait until every expected byte has popped
    task automatic wait_drained();
        push <= 1'b0;
        while (utf8_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Format change only with the block idle; drops a held surrogate,
    // keeps the end-of-string flag
    task automatic write_format(input t_fmt f);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= f;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        cur_fmt        = f;
        high_held      = 1'b0;
        high_held_bits = '0;
    endtask

    // ------------------------------------------------------------------
    // Output side: check each popped byte, stall pop at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_checker
        t_utf8_byte want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                bytes_checked++;
                if (utf8_bytes_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected byte, expected none, got %h last %b",
                             $time, o_out_byte, o_last_of_run);
                end else begin
                    want = utf8_bytes_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        errors++;
                        $display("%0t: out_byte expected %h, got %h",
                                 $time, want.data, o_out_byte);
                    end
                    if (o_last_of_run !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run expected %b, got %b",
                                 $time, want.last, o_last_of_run);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Reset format is UTF-16: length boundaries, upper half of unit ignored
    task automatic test_utf16_ranges();
        send_unit(32'h0000_007F, 1'b0);
        send_unit(32'h0000_0080, 1'b0);
        send_unit(32'h0000_07FF, 1'b0);
        send_unit(32'h0000_0800, 1'b0);
        send_unit(32'h0000_FFFF, 1'b0);
        send_unit(32'hABCD_0001, 1'b1);
    endtask

    task automatic test_utf16_surrogates();
        // lowest and highest supplementary code points
        send_unit(32'h0000_D800, 1'b0);
        send_unit(32'h0000_DC00, 1'b0);
        send_unit(32'h0000_DBFF, 1'b0);
        send_unit(32'h0000_DFFF, 1'b0);
        // lone low surrogate
        send_unit(32'h0000_DFFF, 1'b0);
        // high then high: '?' and the second one is held; then zero gives
        // '?' and ends the string, so the rest of the buffer is dropped
        send_unit(32'h0000_D801, 1'b0);
        send_unit(32'h0000_D802, 1'b0);
        send_unit(32'h0000_0000, 1'b0);
        send_unit(32'h0000_0042, 1'b1);
        // high surrogate as the last unit of a buffer
        send_unit(32'h0000_D834, 1'b1);
    endtask

    task automatic test_utf32_values();
        write_format(FMT_UTF32);
        send_unit(32'h0000_0001, 1'b0);
        send_unit(32'h0010_FFFF, 1'b0);
        send_unit(32'h0011_0000, 1'b0);
        send_unit(32'hFFFF_FFFF, 1'b0);
        send_unit(32'h0000_DFFF, 1'b1);
    endtask

    task automatic test_format_write();
        // held surrogate is dropped silently by a format write
        write_format(FMT_UTF16);
        send_unit(32'h0000_D800, 1'b0);
        write_format(FMT_UTF16);
        send_unit(32'h0000_0041, 1'b1);
        // ended string survives a format write until end of buffer
        send_unit(32'h0000_0000, 1'b0);
        write_format(FMT_UTF32);
        send_unit(32'h0000_0041, 1'b0);
        send_unit(32'h0000_0042, 1'b1);
        send_unit(32'h0000_0043, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly valid text with random content, some noise
    // ------------------------------------------------------------------
    task automatic send_random_utf16();
        int          r;
        logic [15:0] hi16;
        logic [15:0] v;
        logic        eob;
        r    = $urandom_range(99);
        hi16 = 16'($urandom);
        eob  = ($urandom_range(9) == 0);
        if (r < 20) begin
            v = 16'($urandom_range(16'h007F, 16'h0001));
        end else if (r < 38) begin
            v = 16'($urandom_range(16'h07FF, 16'h0080));
        end else if (r < 56) begin
            v = 16'($urandom_range(16'hF7FF, 16'h0800));
            if (v >= HIGH_LO) v = v + 16'h0800;
        end else if (r < 80) begin
            // well-formed pair with random payload
            v = HIGH_LO + 16'($urandom_range(1023));
            send_unit({hi16, v}, 1'b0);
            hi16 = 16'($urandom);
            v    = LOW_LO + 16'($urandom_range(1023));
        end else if (r < 86) begin
            v = LOW_LO + 16'($urandom_range(1023));
        end else if (r < 91) begin
            // broken pair: high followed by a plain character
            v = HIGH_LO + 16'($urandom_range(1023));
            send_unit({hi16, v}, 1'b0);
            v = 16'($urandom_range(16'h007F, 16'h0001));
        end else if (r < 94) begin
            v = 16'h0000;
        end else begin
            v = 16'($urandom);
        end
        send_unit({hi16, v}, eob);
    endtask

    task automatic send_random_utf32();
        int          r;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 20) begin
            v = $urandom_range(32'h7F, 32'h1);
        end else if (r < 35) begin
            v = $urandom_range(32'h7FF, 32'h80);
        end else if (r < 50) begin
            v = $urandom_range(32'hFFFF, 32'h800);
        end else if (r < 75) begin
            v = $urandom_range(32'h10_FFFF, 32'h1_0000);
        end else if (r < 80) begin
            v = $urandom_range(32'hDFFF, 32'hD800);
        end else if (r < 88) begin
            v = $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
        end else if (r < 92) begin
            v = 32'h0;
        end else begin
            v = $urandom;
        end
        send_unit(v, ($urandom_range(9) == 0));
    endtask

    task automatic test_random_traffic();
        int stall_mix [4][2];
        int target;
        stall_mix = '{'{0, 0}, '{46, 0}, '{0, 46}, '{7, 7}};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = stall_mix[p][0];
            recv_stall_pct = stall_mix[p][1];
            for (int f = 0; f < 2; f++) begin
                write_format(f ? FMT_UTF32 : FMT_UTF16);
                target = units_sent + 12;
                while (units_sent < target) begin
                    if (f != 0) send_random_utf32();
                    else        send_random_utf16();
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_utf16_ranges();
        test_utf16_surrogates();
        test_utf32_values();
        test_format_write();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("%0d code units sent (%0d into live strings), %0d bytes checked",
                 units_sent, live_units, bytes_checked);
        $display("both formats, surrogate pairing, ended strings, four stall mixes");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
